[src/wbps_pkg.sv]
package wbps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_BYTES  = 16;
    localparam int LEN_W      = 5;
    localparam int RESULT_W   = 32;
    localparam int OUT_DATA_W = 72;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                has_match;
        logic                has_sum;
        logic [RESULT_W-1:0] start;
        logic [RESULT_W-1:0] total;
    } wbps_rec_t;

endpackage

[src/wbps_core.sv]
module wbps_core #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_accept,
    input  logic [7:0]                        in_byte,
    input  logic                              in_end,
    output logic                              s1_valid,
    output logic                              rec_push,
    output wbps_pkg::wbps_rec_t               rec
);
    import wbps_pkg::*;

    localparam int LEN_CAP   = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
    localparam int WIN_DEPTH = (LEN_CAP > 1) ? LEN_CAP - 1 : 1;
    localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [RESULT_W-1:0] HIT_MAX = '1;

    logic [63:0]            pat_low_reg;
    logic [63:0]            pat_high_reg;
    logic [15:0]            care_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   mode_reg;

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_end_reg;

    logic [7:0]             win_reg [WIN_DEPTH];
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [LEN_W-1:0]       skip_reg;
    logic [RESULT_W-1:0]    hit_count_reg;
    logic                   first_found_reg;

    logic [127:0]           pat_all;
    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       len_m1;
    logic [LEN_W-1:0]       age;
    logic [LEN_W-1:0]       tap;
    logic [7:0]             cand;
    logic                   win_ok;
    logic                   hit;
    logic                   report;
    logic [RESULT_W-1:0]    hit_count_next;
    logic [OFFSET_BITS-1:0] start_full;

    always_comb begin
        pat_all = {pat_high_reg, pat_low_reg};
        eff_len = (len_reg > LEN_CAP_V) ? LEN_CAP_V : len_reg;
        len_m1  = eff_len - 1'b1;
        win_ok  = 1'b1;
        age     = '0;
        tap     = '0;
        cand    = '0;
        for (int j = 0; j < LEN_CAP; j++) begin
            age  = len_m1 - LEN_W'(j);
            tap  = age - 1'b1;
            cand = (age == '0) ? s1_byte_reg : win_reg[tap[WIN_IDX_W-1:0]];
            if ((LEN_W'(j) < eff_len) && care_reg[j] && (cand != pat_all[8*j +: 8])) begin
                win_ok = 1'b0;
            end
        end
        hit = (skip_reg == '0) && (eff_len != '0) &&
              (pos_reg >= OFFSET_BITS'(len_m1)) && win_ok;
        report = hit && (mode_reg || !first_found_reg);
        hit_count_next = (hit && (hit_count_reg != HIT_MAX)) ?
                         hit_count_reg + 1'b1 : hit_count_reg;
        start_full = pos_reg - OFFSET_BITS'(len_m1);
    end

    assign s1_valid      = s1_valid_reg;
    assign rec_push      = s1_valid_reg && (report || s1_end_reg);
    assign rec.has_match = report;
    assign rec.has_sum   = s1_end_reg;
    assign rec.start     = RESULT_W'(start_full);
    assign rec.total     = hit_count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg     <= '0;
            pat_high_reg    <= '0;
            care_reg        <= '1;
            len_reg         <= LEN_W'(1);
            mode_reg        <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_byte_reg     <= '0;
            s1_end_reg      <= 1'b0;
            pos_reg         <= '0;
            skip_reg        <= '0;
            hit_count_reg   <= '0;
            first_found_reg <= 1'b0;
            for (int k = 0; k < WIN_DEPTH; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                    REG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                    REG_CARE:     care_reg     <= cfg_wdata[15:0];
                    REG_LENGTH:   len_reg      <= cfg_wdata[LEN_W-1:0];
                    REG_MODE:     mode_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end

            s1_valid_reg <= in_accept;
            if (in_accept) begin
                s1_byte_reg <= in_byte;
                s1_end_reg  <= in_end;
            end

            if (s1_valid_reg) begin
                if (s1_end_reg) begin
                    pos_reg         <= '0;
                    skip_reg        <= '0;
                    hit_count_reg   <= '0;
                    first_found_reg <= 1'b0;
                    for (int k = 0; k < WIN_DEPTH; k++) begin
                        win_reg[k] <= '0;
                    end
                end else begin
                    if (skip_reg != '0) begin
                        skip_reg <= skip_reg - 1'b1;
                    end else if (hit) begin
                        skip_reg        <= len_m1;
                        first_found_reg <= 1'b1;
                    end
                    hit_count_reg <= hit_count_next;
                    if (pos_reg != POS_MAX) begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                    win_reg[0] <= s1_byte_reg;
                    for (int k = 1; k < WIN_DEPTH; k++) begin
                        win_reg[k] <= win_reg[k-1];
                    end
                end
            end
        end
    end

    a_skip_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (skip_reg != '0) |-> first_found_reg)
        else $error("skip count running without a counted match");

    a_hit_needs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        first_found_reg |-> (hit_count_reg != '0))
        else $error("match flagged but count is zero");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_end_reg) |=> (pos_reg == '0 && hit_count_reg == '0))
        else $error("region state not cleared after region end");

endmodule

[src/wbps_fifo.sv]
module wbps_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  wbps_pkg::wbps_rec_t               push_rec,
    input  logic                              pop,
    output wbps_pkg::wbps_rec_t               head,
    output logic                              head_valid,
    output logic [wbps_pkg::FIFO_CNT_W-1:0]   count
);
    import wbps_pkg::*;

    wbps_rec_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (count_reg != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("result queue underflow");

    a_record_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_rec.has_match || push_rec.has_sum))
        else $error("empty record queued");

endmodule

[src/wbps_out.sv]
module wbps_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wbps_pkg::wbps_rec_t                 head,
    input  logic                                head_valid,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wbps_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import wbps_pkg::*;

    wbps_rec_t rec_reg;
    logic      out_valid_reg;
    logic      phase_reg;
    logic      is_match;
    logic      last_beat;
    logic      advance;
    logic      unique_hit;

    assign is_match   = rec_reg.has_match && !phase_reg;
    assign last_beat  = !(is_match && rec_reg.has_sum);
    assign advance    = !out_valid_reg || (m_tready && last_beat);
    assign pop        = advance && head_valid;
    assign unique_hit = !is_match && (rec_reg.total == RESULT_W'(1));

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_beat;
    assign m_tuser  = is_match ? KIND_MATCH : KIND_SUMMARY;
    assign m_tdata  = {{(OUT_DATA_W - 2*RESULT_W - 1){1'b0}}, unique_hit, rec_reg.total,
                       (is_match ? rec_reg.start : {RESULT_W{1'b0}})};

    always_ff @(posedge aclk) begin
        if (advance) begin
            rec_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= head_valid;
            phase_reg     <= 1'b0;
        end else if (m_tready) begin
            phase_reg <= 1'b1;
        end
    end

    a_valid_record: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (rec_reg.has_match || rec_reg.has_sum))
        else $error("output holds an empty record");

    a_phase_two_beats: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (out_valid_reg && rec_reg.has_match && rec_reg.has_sum))
        else $error("second beat without a two-result record");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

[src/wildcard_byte_pattern_scanner_unit.sv]
// Path: an accepted byte reaches its first result through the input register, then the
//   result queue into the output register; a second follows once the first is taken.
// Throughput: one byte per cycle while s_tready holds; a byte causing a match report
//   and a summary takes two beats. Ready drops as the 4-entry result queue nears full.
// Reset: synchronous, active-low aresetn clears region state, queue and outputs and
//   loads register defaults (care mask all ones, pattern length 1, first-match mode).
module wildcard_byte_pattern_scanner_unit #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // region_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wbps_pkg::OUT_DATA_W-1:0]   m_tdata,   // [31:0] match_start,
                                                         // [63:32] match_total,
                                                         // [64] unique_hit
    output logic                              m_tuser,   // result_kind
    output logic                              m_tlast    // final_result
);
    import wbps_pkg::*;

    logic                  in_accept;
    logic                  s1_valid;
    logic                  rec_push;
    wbps_rec_t             rec;
    wbps_rec_t             head;
    logic                  head_valid;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] fifo_count;

    assign s_tready  = (fifo_count + FIFO_CNT_W'(s1_valid)) <= FIFO_CNT_W'(FIFO_DEPTH - 1);
    assign in_accept = s_tvalid && s_tready;

    wbps_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .s1_valid  (s1_valid),
        .rec_push  (rec_push),
        .rec       (rec)
    );

    wbps_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (rec_push),
        .push_rec   (rec),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .count      (fifo_count)
    );

    wbps_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[dv/signature_hit_checker.sv]
`timescale 1ns / 100ps

module signature_hit_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [wbps_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    output int unsigned                     mismatch_count,
    output int unsigned                     results_owed,
    output int unsigned                     bytes_seen,
    output int unsigned                     reports_seen,
    output int unsigned                     summaries_seen
);
    import wbps_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] start;
        logic [31:0] total;
        logic        uniq;
        logic        is_final;
    } scan_result_t;

    scan_result_t pending_results[$];

    // register copies
    logic [127:0] pat_bytes;
    logic [15:0]  care_bits;
    logic [4:0]   pat_len;
    logic         all_hits;

    // region state
    logic [7:0]   window [0:14];
    logic [31:0]  offset;
    logic [4:0]   skip_left;
    logic [31:0]  hit_total;
    logic         seen_hit;

    task automatic enqueue_result(input scan_result_t item);
        pending_results.insert(pending_results.size(), item);
    endtask

    task automatic clear_region();
        int k;
        for (k = 0; k < 15; k++) begin
            window[k] = 8'h00;
        end
        offset    = '0;
        skip_left = '0;
        hit_total = '0;
        seen_hit  = 1'b0;
    endtask

    task automatic scan_next_byte(input logic [7:0] cur, input logic closing);
        int unsigned  eff;
        int unsigned  j;
        int           k;
        logic         hit;
        logic         report;
        logic [7:0]   seen;
        logic [31:0]  start;
        eff = (pat_len > 16) ? 16 : pat_len;
        report = 1'b0;
        start = '0;
        bytes_seen++;
        if (skip_left != 0) begin
            skip_left--;
        end else if (eff != 0 && offset >= eff - 1) begin
            hit = 1'b1;
            for (j = 0; j < eff; j++) begin
                if (j == eff - 1) begin
                    seen = cur;
                end else begin
                    seen = window[eff - 2 - j];
                end
                if (care_bits[j] && seen != pat_bytes[8*j +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                start = offset - (eff - 1);
                if (hit_total != 32'hFFFF_FFFF) begin
                    hit_total++;
                end
                report = all_hits || !seen_hit;
                seen_hit = 1'b1;
                skip_left = 5'(eff - 1);
            end
        end
        if (report) begin
            enqueue_result('{KIND_MATCH, start, hit_total, 1'b0, !closing});
        end
        if (closing) begin
            enqueue_result('{KIND_SUMMARY, 32'd0, hit_total,
                             hit_total == 32'd1, 1'b1});
            clear_region();
            return;
        end
        for (k = 14; k > 0; k--) begin
            window[k] = window[k-1];
        end
        window[0] = cur;
        if (offset != 32'hFFFF_FFFF) begin
            offset++;
        end
    endtask

    task automatic check_result();
        scan_result_t want;
        scan_result_t got;
        got.kind     = m_tuser;
        got.start    = m_tdata[31:0];
        got.total    = m_tdata[63:32];
        got.uniq     = m_tdata[64];
        got.is_final = m_tlast;
        if (got.kind == KIND_SUMMARY) begin
            summaries_seen++;
        end else begin
            reports_seen++;
        end
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected transfer: kind %0d start %0d total %0d",
                         got.kind, got.start, got.total);
                $display("    unique %0d last %0d", got.uniq, got.is_final);
            end
        end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("mismatch at %0t: expected kind %0d start %0d total %0d",
                             $realtime, want.kind, want.start, want.total);
                    $display("    expected unique %0d last %0d", want.uniq, want.is_final);
                    $display("    got kind %0d start %0d total %0d unique %0d last %0d",
                             got.kind, got.start, got.total, got.uniq, got.is_final);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes = '0;
            care_bits = 16'hFFFF;
            pat_len   = 5'd1;
            all_hits  = 1'b0;
            clear_region();
            pending_results.delete();
            mismatch_count = 0;
            bytes_seen     = 0;
            reports_seen   = 0;
            summaries_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PAT_LOW: begin
                        pat_bytes[63:0] = cfg_wdata;
                    end
                    REG_PAT_HIGH: begin
                        pat_bytes[127:64] = cfg_wdata;
                    end
                    REG_CARE: begin
                        care_bits = cfg_wdata[15:0];
                    end
                    REG_LENGTH: begin
                        pat_len = cfg_wdata[4:0];
                    end
                    REG_MODE: begin
                        all_hits = cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                scan_next_byte(s_tdata, s_tlast);
            end
        end
        results_owed = pending_results.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import wbps_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1050;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int unsigned mismatch_count;
    int unsigned results_owed;
    int unsigned bytes_seen;
    int unsigned reports_seen;
    int unsigned summaries_seen;

    // stimulus-side view of the registers
    logic [127:0] cur_pat;
    logic [15:0]  cur_care;
    logic [4:0]   cur_len;
    logic         cur_mode;
    int unsigned  bytes_sent;
    int unsigned  phase_count;
    int unsigned  calm_left [2];

    wildcard_byte_pattern_scanner_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    signature_hit_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed),
        .bytes_seen     (bytes_seen),
        .reports_seen   (reports_seen),
        .summaries_seen (summaries_seen)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // side 0: byte source, side 1: result sink
    function automatic int unsigned pick_gap(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left[side] = $urandom_range(10, 50);
            return 0;
        end
        if ($urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic closing);
        int unsigned gap;
        gap = pick_gap(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= closing;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_packed(input logic [63:0] bytes, input int n, input logic closing);
        int i;
        for (i = 0; i < n; i++) begin
            send_byte(bytes[8*i +: 8], closing && i == n - 1);
        end
    endtask

    // let the last transfers drain before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic program_regs(input logic [127:0] pat, input logic [15:0] care,
                                input logic [4:0] len, input logic mode);
        cur_pat  = pat;
        cur_care = care;
        cur_len  = len;
        cur_mode = mode;
        phase_count++;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PAT_LOW;
        cfg_wdata <= pat[63:0];
        @(negedge aclk);
        cfg_index <= REG_PAT_HIGH;
        cfg_wdata <= pat[127:64];
        @(negedge aclk);
        cfg_index <= REG_CARE;
        cfg_wdata <= CFG_DATA_W'(care);
        @(negedge aclk);
        cfg_index <= REG_LENGTH;
        cfg_wdata <= CFG_DATA_W'(len);
        @(negedge aclk);
        cfg_index <= REG_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one region: planted signatures, near misses and noise
    task automatic scan_region(input int unsigned target, input int unsigned goal);
        logic [7:0]  bytes_q[$];
        int unsigned eff;
        int unsigned j;
        int unsigned k;
        logic        closing;
        eff = (cur_len > 16) ? 16 : cur_len;
        while (bytes_q.size() < target) begin
            if (eff > 0 && bytes_q.size() + eff <= target && $urandom_range(0, 9) < 4) begin
                for (j = 0; j < eff; j++) begin
                    bytes_q.insert(bytes_q.size(),
                                   cur_care[j] ? cur_pat[8*j +: 8] : 8'($urandom));
                end
                if ($urandom_range(0, 3) == 0) begin
                    k = bytes_q.size() - 1 - $urandom_range(0, eff - 1);
                    bytes_q[k] = bytes_q[k] ^ (8'h01 << $urandom_range(0, 7));
                end
            end else if ($urandom_range(0, 1) == 0) begin
                bytes_q.insert(bytes_q.size(), cur_pat[8*$urandom_range(0, 15) +: 8]);
            end else begin
                bytes_q.insert(bytes_q.size(), 8'($urandom));
            end
        end
        closing = !(bytes_sent + bytes_q.size() >= goal && $urandom_range(0, 3) == 0);
        for (j = 0; j < bytes_q.size(); j++) begin
            send_byte(bytes_q[j], closing && j == bytes_q.size() - 1);
        end
    endtask

    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            int unsigned gap;
            gap = pick_gap(1);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        #5_000_000;
        $display("timeout waiting for transfers");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int unsigned    target;
        int unsigned    goal;
        int unsigned    waited;
        int unsigned    eff;
        logic [127:0]   pat;
        logic [15:0]    care;
        logic [4:0]     len;
        int unsigned    pick;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cur_pat   = '0;
        cur_care  = 16'hFFFF;
        cur_len   = 5'd1;
        cur_mode  = 1'b0;
        bytes_sent  = 0;
        phase_count = 1;
        calm_left[0] = 0;
        calm_left[1] = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: single zero byte, first mode still counts the second hit
        send_packed(64'h00_FF_00, 3, 1'b1);
        settle();
        // exact four-byte signature, all mode, hit on the closing byte, then a short region
        program_regs({64'h0, 64'hDDCC_BBAA}, 16'hFFFF, 5'd4, 1'b1);
        send_packed(64'hDDCC_BBAA_DDCC_BBAA, 8, 1'b1);
        send_packed(64'hCC_BBAA, 3, 1'b1);
        settle();
        // middle bytes wildcarded, first mode
        program_regs({64'h0, 64'hDDCC_BBAA}, 16'h0009, 5'd4, 1'b0);
        send_packed(64'hDD00_00AA_DD34_12AA, 8, 1'b1);
        settle();

        while (bytes_sent < RANDOM_BYTES + 22) begin
            case (phase_count)
                4: begin
                    pat = {128{1'b1}}; care = 16'hFFFF; len = 5'd16;
                end
                5: begin
                    pat = '0; care = 16'h0000; len = 5'd31;
                end
                6: begin
                    pat = {$urandom, $urandom, $urandom, $urandom}; care = 16'hFFFF; len = 5'd0;
                end
                7: begin
                    pat = {$urandom, $urandom, $urandom, $urandom}; care = 16'h0000; len = 5'd1;
                end
                default: begin
                    pat = {$urandom, $urandom, $urandom, $urandom};
                    care = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                    pick = $urandom_range(0, 19);
                    if (pick == 0) begin
                        len = 5'd0;
                    end else if (pick == 1) begin
                        len = 5'($urandom_range(17, 31));
                    end else begin
                        len = 5'($urandom_range(1, 16));
                    end
                end
            endcase
            program_regs(pat, care, len, phase_count[0]);
            eff  = (cur_len > 16) ? 16 : cur_len;
            goal = bytes_sent + $urandom_range(40, 110);
            while (bytes_sent < goal) begin
                pick = $urandom_range(0, 9);
                if (pick == 0 && eff > 1) begin
                    target = $urandom_range(1, eff - 1);
                end else if (pick == 1) begin
                    target = $urandom_range(49, 150);
                end else begin
                    target = $urandom_range(1, 48);
                end
                scan_region(target, goal);
            end
            settle();
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (results_owed != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (10) @(negedge aclk);
        if (results_owed != 0) begin
            $display("%0d expected results never arrived", results_owed);
        end
        $display("Scanned %0d bytes under %0d register settings (lengths 0 to 31, both modes).",
                 bytes_seen, phase_count);
        $display("Checked %0d match reports and %0d region summaries against the prediction.",
                 reports_seen, summaries_seen);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
